// ===== sv/bts_pkg.sv =====
package bts_pkg;

	// Field widths
	localparam int POS_BITS   = 32;
	localparam int PROB_BITS  = 16;
	localparam int COUNT_BITS = 16;
	localparam int DOC_BITS   = 16;

	// Accumulated probability sum never wraps: the count saturates first
	localparam int SUM_BITS  = PROB_BITS + COUNT_BITS;
	localparam int ITER_BITS = $clog2(PROB_BITS + 1);

	typedef enum logic [1:0] {
		TAG_O = 2'd0,
		TAG_I = 2'd1,
		TAG_B = 2'd2,
		TAG_E = 2'd3
	} tag_t;

	typedef struct packed {
		tag_t                 tag;
		logic [PROB_BITS-1:0] prob;
		logic [DOC_BITS-1:0]  doc_id;
		logic [POS_BITS-1:0]  char_start;
		logic [POS_BITS-1:0]  doc_text_len;
		logic                 last_token;
	} tok_item_t;

	typedef struct packed {
		logic [DOC_BITS-1:0]  span_doc;
		logic [POS_BITS-1:0]  span_start;
		logic [POS_BITS-1:0]  span_end;
		logic [PROB_BITS-1:0] mean_prob;
		logic                 last_of_run;
	} span_item_t;

	// Result offered by the sequencer to the output register
	typedef struct packed {
		logic       valid;
		span_item_t item;
	} emit_req_t;

	// Divider handoff to the sequencer
	typedef struct packed {
		logic                 done;
		logic [PROB_BITS-1:0] quot;
	} div_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PEND,
		ST_DOC,
		ST_DOC_DIV,
		ST_DOC_EMIT,
		ST_TAG,
		ST_TAG_DIV,
		ST_TAG_EMIT,
		ST_LAST,
		ST_LAST_DIV,
		ST_LAST_EMIT
	} ctrl_state_t;

endpackage

// ===== sv/bio_tag_span_extractor_top.sv =====
// Channel  Direction  Handshake              Payload
// tok      in         tok_valid / tok_stall  tok_item_t: tag, prob, doc, start, length, last
// span     out        span_valid/span_stall  span_item_t: doc, start, end, mean, last_of_run
// cfg      in         cfg_we                 cfg_wdata: bioe_mode
//
// A token walks the pending, document, tag and last steps. Each span it closes and
// sends adds a divider run, its done pulse and the output load, at most two per
// token; an E close skips the output load, its span is held and leaves in the next
// token's pending step. The shared restoring divider gives one quotient bit per cycle.
// tok_stall is high from the accepting edge until the token is fully handled.
// A closed span waits in the output register; a stalled span stalls the sequencer.
// Reset is asynchronous, active low, and clears span tracking state and bioe_mode, not the span payload.
module bio_tag_span_extractor_top
	import bts_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	input  logic       tok_valid,
	output logic       tok_stall,
	input  tok_item_t  tok,
	output logic       span_valid,
	input  logic       span_stall,
	output span_item_t span
);

	logic                  busy;
	emit_req_t             emit;
	logic                  emit_ack;
	logic                  div_start;
	logic [SUM_BITS-1:0]   div_dvd;
	logic [COUNT_BITS-1:0] div_dvs;
	div_rsp_t              div_rsp;

	logic       span_valid_q;
	span_item_t span_q;
	logic       out_free;

	bts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.tok_valid (tok_valid),
		.tok       (tok),
		.busy      (busy),
		.emit      (emit),
		.emit_ack  (emit_ack),
		.div_start (div_start),
		.div_dvd   (div_dvd),
		.div_dvs   (div_dvs),
		.div       (div_rsp)
	);

	bts_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.dvd    (div_dvd),
		.dvs    (div_dvs),
		.rsp    (div_rsp)
	);

	assign tok_stall = busy;

	// Output register: loads when empty or draining in the same cycle
	assign out_free = !span_valid_q || !span_stall;
	assign emit_ack = emit.valid && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_valid_q <= 1'b0;
		end else if (emit_ack) begin
			span_valid_q <= 1'b1;
		end else if (!span_stall) begin
			span_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_ack) span_q <= emit.item;
	end

	assign span_valid = span_valid_q;
	assign span       = span_q;

endmodule

// ===== sv/bts_div.sv =====
module bts_div
	import bts_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [SUM_BITS-1:0]   dvd,
	input  logic [COUNT_BITS-1:0] dvs,
	output div_rsp_t              rsp
);

	logic                  busy_q;
	logic                  done_q;
	logic                  zero_q;
	logic [ITER_BITS-1:0]  iter_q;
	logic [COUNT_BITS-1:0] rem_q;
	logic [PROB_BITS-1:0]  quo_q;
	logic [COUNT_BITS-1:0] dvs_q;

	logic [COUNT_BITS:0] trial;
	logic [COUNT_BITS:0] diff;
	logic                ge;

	// One restoring step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		trial = {rem_q, quo_q[PROB_BITS-1]};
		diff  = trial - {1'b0, dvs_q};
		ge    = (trial >= {1'b0, dvs_q});
	end

	// Control: iteration count and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= ITER_BITS'(PROB_BITS);
			end else if (busy_q) begin
				iter_q <= iter_q - 1'b1;
				if (iter_q == ITER_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: high part of the sum seeds the remainder (quotient fits PROB_BITS)
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= dvd[SUM_BITS-1:PROB_BITS];
			quo_q  <= dvd[PROB_BITS-1:0];
			dvs_q  <= dvs;
			zero_q <= (dvs == '0);
		end else if (busy_q) begin
			rem_q <= ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
			quo_q <= {quo_q[PROB_BITS-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = zero_q ? '0 : quo_q;

endmodule

// ===== sv/bts_ctrl.sv =====
module bts_ctrl
	import bts_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_wdata,
	input  logic                  tok_valid,
	input  tok_item_t             tok,
	output logic                  busy,
	output emit_req_t             emit,
	input  logic                  emit_ack,
	output logic                  div_start,
	output logic [SUM_BITS-1:0]   div_dvd,
	output logic [COUNT_BITS-1:0] div_dvs,
	input  div_rsp_t              div
);

	ctrl_state_t state_q, state_d;

	logic                  bioe_q;
	logic                  open_q;
	logic [POS_BITS-1:0]   open_start_q;
	logic [SUM_BITS-1:0]   sum_q;
	logic [COUNT_BITS-1:0] count_q;
	logic                  pend_q;
	logic [POS_BITS-1:0]   pend_start_q;
	logic [PROB_BITS-1:0]  pend_mean_q;
	logic [DOC_BITS-1:0]   pend_doc_q;
	logic [DOC_BITS-1:0]   prev_doc_q;
	logic [POS_BITS-1:0]   prev_len_q;
	logic                  seen_q;
	tok_item_t             item_q;

	// Which closes this token causes, fixed at accept time
	logic fl_chg_q, fl_pend_q, fl_doc_q, fl_tag_q, fl_last_q;

	logic accept;
	logic chg_in, open_a, is_e_in, e_tag, open_b, e_last;
	logic is_e_q, tag_close;
	logic clr_acc, finish, store_pend, pend_done, stream_end;

	logic                  open_base;
	logic [SUM_BITS-1:0]   sum_base;
	logic [COUNT_BITS-1:0] count_base;
	logic                  open_d;
	logic [SUM_BITS-1:0]   sum_d;
	logic [COUNT_BITS-1:0] count_d;

	assign accept = tok_valid && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	// Predict the closes of the incoming token from the current state
	always_comb begin
		chg_in  = seen_q && (tok.doc_id != prev_doc_q);
		open_a  = open_q && !chg_in;
		is_e_in = bioe_q && (tok.tag == TAG_E);
		e_tag   = open_a && !is_e_in && (tok.tag == TAG_O || tok.tag == TAG_B);
		open_b  = (open_a && !e_tag && !(is_e_in && !tok.last_token)) || (tok.tag == TAG_B);
		e_last  = tok.last_token && open_b;
	end

	// Close decision for the latched token at the tag step
	always_comb begin
		is_e_q    = bioe_q && (item_q.tag == TAG_E);
		tag_close = open_q && ((is_e_q && !item_q.last_token) ||
			(!is_e_q && (item_q.tag == TAG_O || item_q.tag == TAG_B)));
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:      if (accept) state_d = ST_PEND;
			ST_PEND:      if (!fl_pend_q || emit_ack) state_d = ST_DOC;
			ST_DOC:       state_d = (fl_chg_q && open_q) ? ST_DOC_DIV : ST_TAG;
			ST_DOC_DIV:   if (div.done) state_d = ST_DOC_EMIT;
			ST_DOC_EMIT:  if (emit_ack) state_d = ST_TAG;
			ST_TAG:       state_d = tag_close ? ST_TAG_DIV : ST_LAST;
			ST_TAG_DIV:   if (div.done) state_d = is_e_q ? ST_LAST : ST_TAG_EMIT;
			ST_TAG_EMIT:  if (emit_ack) state_d = ST_LAST;
			ST_LAST: begin
				if (item_q.last_token && open_q) state_d = ST_LAST_DIV;
				else state_d = ST_IDLE;
			end
			ST_LAST_DIV:  if (div.done) state_d = ST_LAST_EMIT;
			ST_LAST_EMIT: if (emit_ack) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// Outputs and update strobes
	always_comb begin
		emit       = '0;
		div_start  = 1'b0;
		clr_acc    = 1'b0;
		finish     = 1'b0;
		store_pend = 1'b0;
		pend_done  = 1'b0;
		stream_end = 1'b0;
		unique case (state_q)
			ST_PEND: begin
				if (fl_pend_q) begin
					emit.valid            = 1'b1;
					emit.item.span_doc    = pend_doc_q;
					emit.item.span_start  = pend_start_q;
					emit.item.span_end    = item_q.char_start;
					emit.item.mean_prob   = pend_mean_q;
					emit.item.last_of_run = !(fl_doc_q || fl_tag_q || fl_last_q);
					pend_done             = emit_ack;
				end
			end
			ST_DOC: begin
				if (fl_chg_q && open_q) div_start = 1'b1;
				else if (fl_chg_q) clr_acc = 1'b1;
			end
			ST_DOC_EMIT: begin
				emit.valid            = 1'b1;
				emit.item.span_doc    = prev_doc_q;
				emit.item.span_start  = open_start_q;
				emit.item.span_end    = prev_len_q;
				emit.item.mean_prob   = div.quot;
				emit.item.last_of_run = !(fl_tag_q || fl_last_q);
				clr_acc               = emit_ack;
			end
			ST_TAG: begin
				if (tag_close) div_start = 1'b1;
				else finish = 1'b1;
			end
			ST_TAG_DIV: begin
				if (div.done && is_e_q) begin
					store_pend = 1'b1;
					clr_acc    = 1'b1;
					finish     = 1'b1;
				end
			end
			ST_TAG_EMIT: begin
				emit.valid            = 1'b1;
				emit.item.span_doc    = item_q.doc_id;
				emit.item.span_start  = open_start_q;
				emit.item.span_end    = item_q.char_start;
				emit.item.mean_prob   = div.quot;
				emit.item.last_of_run = !fl_last_q;
				clr_acc               = emit_ack;
				finish                = emit_ack;
			end
			ST_LAST: begin
				if (item_q.last_token && open_q) div_start = 1'b1;
				else if (item_q.last_token) stream_end = 1'b1;
			end
			ST_LAST_EMIT: begin
				emit.valid            = 1'b1;
				emit.item.span_doc    = item_q.doc_id;
				emit.item.span_start  = open_start_q;
				emit.item.span_end    = item_q.doc_text_len;
				emit.item.mean_prob   = div.quot;
				emit.item.last_of_run = 1'b1;
				stream_end            = emit_ack;
			end
			default: ;
		endcase
	end

	assign div_dvd = sum_q;
	assign div_dvs = count_q;

	// Accumulators after an optional clear, then the token's own update
	always_comb begin
		open_base  = (clr_acc || stream_end) ? 1'b0 : open_q;
		sum_base   = (clr_acc || stream_end) ? '0 : sum_q;
		count_base = (clr_acc || stream_end) ? '0 : count_q;
		open_d     = open_base;
		sum_d      = sum_base;
		count_d    = count_base;
		if (finish) begin
			if (item_q.tag == TAG_B) open_d = 1'b1;
			// B and I add in until the count saturates
			if ((item_q.tag == TAG_I || item_q.tag == TAG_B) && (count_base != '1)) begin
				sum_d   = sum_base + SUM_BITS'(item_q.prob);
				count_d = count_base + 1'b1;
			end
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			bioe_q    <= 1'b0;
			open_q    <= 1'b0;
			pend_q    <= 1'b0;
			seen_q    <= 1'b0;
			fl_chg_q  <= 1'b0;
			fl_pend_q <= 1'b0;
			fl_doc_q  <= 1'b0;
			fl_tag_q  <= 1'b0;
			fl_last_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) bioe_q <= cfg_wdata;
			if (accept) begin
				fl_chg_q  <= chg_in;
				fl_pend_q <= pend_q;
				fl_doc_q  <= chg_in && open_q;
				fl_tag_q  <= e_tag;
				fl_last_q <= e_last;
			end
			open_q <= open_d;
			if (store_pend) pend_q <= 1'b1;
			else if (pend_done || stream_end) pend_q <= 1'b0;
			if (stream_end) seen_q <= 1'b0;
			else if (finish) seen_q <= 1'b1;
		end
	end

	// Span state and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_start_q <= '0;
			sum_q        <= '0;
			count_q      <= '0;
			pend_start_q <= '0;
			pend_mean_q  <= '0;
			pend_doc_q   <= '0;
			prev_doc_q   <= '0;
			prev_len_q   <= '0;
		end else begin
			sum_q   <= sum_d;
			count_q <= count_d;
			if (finish) begin
				prev_doc_q <= item_q.doc_id;
				prev_len_q <= item_q.doc_text_len;
				if (item_q.tag == TAG_B) open_start_q <= item_q.char_start;
			end
			if (store_pend) begin
				pend_doc_q   <= item_q.doc_id;
				pend_start_q <= open_start_q;
				pend_mean_q  <= div.quot;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) item_q <= tok;
	end

endmodule

// ===== sv/bts_chk.sv =====
module bts_chk
	import bts_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       tok_valid,
	input logic       tok_stall,
	input logic       span_valid,
	input logic       span_stall,
	input span_item_t span
);

	// A stalled span stays offered and unchanged
	assert property (@(posedge clk) disable iff (!arst_n)
		span_valid && span_stall |=> span_valid && $stable(span))
		else $error("stalled span dropped or changed");

	// A token transfer makes the block busy
	assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && !tok_stall |=> tok_stall)
		else $error("no busy period after token transfer");

	// Busy only starts from a token transfer
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(tok_stall) |-> $past(tok_valid))
		else $error("busy without a token transfer");

endmodule

bind bio_tag_span_extractor_top bts_chk u_bts_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.tok_valid  (tok_valid),
	.tok_stall  (tok_stall),
	.span_valid (span_valid),
	.span_stall (span_stall),
	.span       (span)
);
